// ===== rtl/core/sharpen_filter_3x3_macros.svh =====
// assertion macros for the sharpen filter rtl
`ifndef SHARPEN_FILTER_3X3_MACROS_SVH
`define SHARPEN_FILTER_3X3_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define SF3_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sf3 assertion failed");
// next-cycle implication, disabled in reset
`define SF3_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sf3 assertion failed");
`else
`define SF3_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define SF3_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/sf3_pkg.sv =====
// shared types and constants of the sharpen filter
package sf3_pkg;

    localparam int PIX_W      = 8;
    localparam int OUT_ROW_W  = 12;
    localparam int OUT_COL_W  = 10;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;

    typedef logic [PIX_W-1:0]      pixel_t;
    typedef logic [OUT_ROW_W-1:0]  row_out_t;
    typedef logic [OUT_COL_W-1:0]  col_out_t;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    // 3x3 neighborhood, [row][col], col 2 is the newest pixel
    typedef pixel_t [2:0][2:0] window_t;

    // register indexes of the write port
    localparam cfg_addr_t CFG_FRAME_WIDTH  = 2'd0;
    localparam cfg_addr_t CFG_FRAME_HEIGHT = 2'd1;
    localparam cfg_addr_t CFG_MAX_GREY     = 2'd2;

    localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam pixel_t          RST_MAX_GREY     = 8'd255;

endpackage

// ===== rtl/core/sf3_if.sv =====
// stream interfaces for pixels in and filtered results out
interface sf3_pix_if;
    logic             valid;
    logic             ready;
    sf3_pkg::pixel_t  pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface sf3_res_if;
    logic               valid;
    logic               ready;
    sf3_pkg::pixel_t    sharpened_value;
    sf3_pkg::row_out_t  out_row;
    sf3_pkg::col_out_t  out_column;
    logic               frame_done;

    modport source (output valid, output sharpened_value, output out_row,
                    output out_column, output frame_done, input ready);
    modport sink   (input valid, input sharpened_value, input out_row,
                    input out_column, input frame_done, output ready);
endinterface

// ===== rtl/core/sharpen_filter_3x3.sv =====
// top level of the 3x3 laplacian sharpen filter
//
//  channel   dir  handshake      payload
//  pix_in    in   valid/ready    pixel_value
//  res_out   out  valid/ready    sharpened_value, out_row, out_column, frame_done
//  cfg       in   cfg_we only    cfg_addr, cfg_data
//
//  one pixel per cycle while res_out is not stalled; the single line memory
//  takes one read and one write a cycle; results pass s1, s2 and the output register
//  border pixels pass through the pipeline and produce no transaction
//  reset clears counters, window, pipeline valids and loads the default geometry
//  a stalled res_out backs up through two stages before pix_in.ready drops
`include "sharpen_filter_3x3_macros.svh"

module sharpen_filter_3x3
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    sf3_pix_if.sink                     pix_in,
    sf3_res_if.source                   res_out,
    input  logic                        cfg_we,
    input  sf3_pkg::cfg_addr_t          cfg_addr,
    input  logic [sf3_pkg::CFG_DATA_W-1:0] cfg_data
);

    // counter and bound widths
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int PW    = sf3_pkg::PIX_W;

    // position tag that rides along with each pixel
    typedef struct packed {
        logic               emit;
        logic               done;
        sf3_pkg::row_out_t  row;
        sf3_pkg::col_out_t  col;
    } tag_t;

    function automatic logic [WW-1:0] clamp_width(input logic [sf3_pkg::FW_W-1:0] v);
        logic [WW-1:0] res;
        if (v < sf3_pkg::FW_W'(3))
            res = WW'(3);
        else if (32'(v) > MAX_WIDTH)
            res = WW'(MAX_WIDTH);
        else
            res = WW'(v);
        return res;
    endfunction

    function automatic logic [HW-1:0] clamp_height(input logic [sf3_pkg::FH_W-1:0] v);
        logic [HW-1:0] res;
        if (v < sf3_pkg::FH_W'(3))
            res = HW'(3);
        else if (32'(v) > MAX_HEIGHT)
            res = HW'(MAX_HEIGHT);
        else
            res = HW'(v);
        return res;
    endfunction

    // ---------------------------------------------------------------
    // configuration: geometry is stored already clamped
    // ---------------------------------------------------------------
    logic [WW-1:0]   width_reg;
    logic [HW-1:0]   height_reg;
    sf3_pkg::pixel_t max_grey_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= clamp_width(sf3_pkg::RST_FRAME_WIDTH);
            height_reg   <= clamp_height(sf3_pkg::RST_FRAME_HEIGHT);
            max_grey_reg <= sf3_pkg::RST_MAX_GREY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                sf3_pkg::CFG_FRAME_WIDTH:
                    width_reg <= clamp_width(cfg_data[sf3_pkg::FW_W-1:0]);
                sf3_pkg::CFG_FRAME_HEIGHT:
                    height_reg <= clamp_height(cfg_data[sf3_pkg::FH_W-1:0]);
                sf3_pkg::CFG_MAX_GREY:
                    max_grey_reg <= cfg_data[PW-1:0];
                default:
                    ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // pipeline control
    // ---------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s1_adv, s2_adv, out_load, in_fire;

    tag_t                s1_tag_reg, s2_tag_reg;
    sf3_pkg::pixel_t     s1_pix_reg;
    logic [COL_W-1:0]    s1_addr_reg;

    // s2 drops border pixels, only interior ones need the output register
    assign s2_adv   = s2_valid_reg &&
                      (!s2_tag_reg.emit || !out_valid_reg || res_out.ready);
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign out_load = s2_adv && s2_tag_reg.emit;

    assign pix_in.ready = !s1_valid_reg || s1_adv;
    assign in_fire      = pix_in.valid && pix_in.ready;

    // ---------------------------------------------------------------
    // raster position of the incoming pixel
    // ---------------------------------------------------------------
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [WW-1:0]    col_ext, col_inc;
    logic [HW-1:0]    row_ext, row_inc;
    logic             line_end, frame_end;
    logic [31:0]      row_m1, col_m1;
    tag_t             in_tag;

    assign col_ext   = WW'(col_reg);
    assign col_inc   = col_ext + WW'(1);
    assign row_ext   = HW'(row_reg);
    assign row_inc   = row_ext + HW'(1);
    assign line_end  = col_inc >= width_reg;
    assign frame_end = row_inc >= height_reg;
    assign row_m1    = 32'(row_reg) - 32'd1;
    assign col_m1    = 32'(col_reg) - 32'd1;

    // the window centered one row up and one column left is complete here
    assign in_tag.emit = (row_reg >= ROW_W'(2)) && (row_ext < height_reg) &&
                         (col_reg >= COL_W'(2)) && (col_ext < width_reg);
    assign in_tag.done = (row_inc == height_reg) && (col_inc == width_reg);
    assign in_tag.row  = row_m1[sf3_pkg::OUT_ROW_W-1:0];
    assign in_tag.col  = col_m1[sf3_pkg::OUT_COL_W-1:0];

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_fire)
        begin
            if (line_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : ROW_W'(row_inc);
            end
            else
            begin
                col_next = COL_W'(col_inc);
            end
        end
    end

    // ---------------------------------------------------------------
    // line memory: {upper row, middle row} per column
    // read on accept, written back when the pixel leaves s1; neighboring
    // pixels always sit in different columns so the two never collide
    // ---------------------------------------------------------------
    logic [2*PW-1:0] line_mem [MAX_WIDTH];
    logic [2*PW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
            rd_data_reg <= line_mem[col_reg];
        if (s1_adv)
            line_mem[s1_addr_reg] <= {rd_data_reg[PW-1:0], s1_pix_reg};
    end

    // ---------------------------------------------------------------
    // window shift as the pixel moves from s1 to s2
    // ---------------------------------------------------------------
    sf3_pkg::window_t win_reg, win_next;

    always_comb
    begin
        win_next = win_reg;
        if (s1_adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_next[i][0] = win_reg[i][1];
                win_next[i][1] = win_reg[i][2];
            end
            win_next[0][2] = rd_data_reg[2*PW-1:PW];
            win_next[1][2] = rd_data_reg[PW-1:0];
            win_next[2][2] = s1_pix_reg;
        end
    end

    // valid bits of the stages and the output register
    always_comb
    begin
        s1_valid_next  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        s2_valid_next  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_reg);
        out_valid_next = out_load ? 1'b1 :
                         (res_out.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            win_reg       <= '0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            win_reg       <= win_next;
        end
    end

    // payload of s1 and s2
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg  <= pix_in.pixel_value;
            s1_addr_reg <= col_reg;
            s1_tag_reg  <= in_tag;
        end
        if (s1_adv)
            s2_tag_reg <= s1_tag_reg;
    end

    // ---------------------------------------------------------------
    // kernel and output register
    // ---------------------------------------------------------------
    sf3_pkg::pixel_t   kernel_value;
    sf3_pkg::pixel_t   out_value_reg;
    sf3_pkg::row_out_t out_row_reg;
    sf3_pkg::col_out_t out_col_reg;
    logic              out_done_reg;

    sf3_kernel u_kernel
    (
        .win      (win_reg),
        .max_grey (max_grey_reg),
        .value    (kernel_value)
    );

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= kernel_value;
            out_row_reg   <= s2_tag_reg.row;
            out_col_reg   <= s2_tag_reg.col;
            out_done_reg  <= s2_tag_reg.done;
        end
    end

    assign res_out.valid           = out_valid_reg;
    assign res_out.sharpened_value = out_value_reg;
    assign res_out.out_row         = out_row_reg;
    assign res_out.out_column      = out_col_reg;
    assign res_out.frame_done      = out_done_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `SF3_ASSERT_IMPL(a_mem_rw_distinct, clk, rst_n, in_fire && s1_adv, col_reg != s1_addr_reg)
    `SF3_ASSERT_IMPL(a_no_overwrite, clk, rst_n, out_valid_reg && !res_out.ready, !out_load)
    `SF3_ASSERT_NEXT(a_frame_wrap, clk, rst_n, in_fire && in_tag.emit && in_tag.done, (col_reg == '0) && (row_reg == '0))
    `SF3_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !s1_adv, s1_valid_reg && $stable(s1_addr_reg))

endmodule

// ===== rtl/core/sf3_kernel.sv =====
// laplacian sharpen kernel with clamp to [0, max grey]
module sf3_kernel
(
    input  sf3_pkg::window_t win,
    input  sf3_pkg::pixel_t  max_grey,
    output sf3_pkg::pixel_t  value
);

    logic [11:0]        sum;
    logic [11:0]        center_x10;
    logic signed [12:0] acc;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sum = sum + 12'(win[i][j]);
            end
        end
    end

    // 10*center - sum of all nine = 9*center - neighbors
    assign center_x10 = {1'b0, win[1][1], 3'b000} + {3'b000, win[1][1], 1'b0};
    assign acc        = $signed({1'b0, center_x10}) - $signed({1'b0, sum});

    always_comb
    begin
        priority if (acc < 13'sd0)
        begin
            value = '0;
        end
        else if (acc > $signed({5'b00000, max_grey}))
        begin
            value = max_grey;
        end
        else
        begin
            value = acc[7:0];
        end
    end

endmodule
